>>> src/wvac_pkg.sv
package wvac_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int CODE_BITS  = 3;
    localparam int USED_W     = 4;
    localparam int NUM_THRESH = 7;
    localparam int CFG_IDX_W  = 3;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [CODE_BITS-1:0] code_t;
    typedef logic [USED_W-1:0]   used_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef sample_t thresh_arr_t [NUM_THRESH];

    localparam code_t CODE_N  = 3'd0;
    localparam code_t CODE_NE = 3'd1;
    localparam code_t CODE_E  = 3'd2;
    localparam code_t CODE_SE = 3'd3;
    localparam code_t CODE_S  = 3'd4;
    localparam code_t CODE_SW = 3'd5;
    localparam code_t CODE_W  = 3'd6;

    localparam thresh_arr_t THRESH_RESET = '{
        12'd800, 12'd1000, 12'd1100, 12'd1200, 12'd1300, 12'd1500, 12'd1900
    };

    // Heading given when the mean falls below threshold i and below no earlier one.
    localparam code_t BAND_CODE [NUM_THRESH] = '{
        CODE_N, CODE_SW, CODE_NE, CODE_W, CODE_SE, CODE_N, CODE_E
    };

    function automatic code_t classify(sample_t mean, thresh_arr_t th);
        code_t code;
        logic  hit;
        code = CODE_S;
        hit  = 1'b0;
        for (int i = 0; i < NUM_THRESH; i++)
        begin
            if (!hit && (mean < th[i]))
            begin
                code = BAND_CODE[i];
                hit  = 1'b1;
            end
        end
        return code;
    endfunction

endpackage

>>> src/wind_vane_average_classifier_unit.sv
// Wind-vane moving average with direction classification.
//
// Input channel (in_valid/in_ready, vane_sample): one 12-bit ADC reading per
// item. Output channel (out_valid/out_ready): the truncated mean of the last
// DEPTH samples (fewer during warm-up), its heading code and the sample count.
// Thresholds are to be written through cfg_wr_en/cfg_index/cfg_wdata while
// idle, not enforced by the block; an index beyond the seventh is ignored.
//
// The front end takes a new item only once it has pushed the running total of
// the last one into a two-entry queue. The back end divides each total by the
// sample count with a bit-serial divider, one quotient bit per cycle, and then
// classifies and registers the result. It pops the next total only once the
// previous result has been loaded into the output register.
//
// Reset clears the ring state to warm-up and restores the default thresholds.
// A stalled receiver holds the output register; behind it the back end holds
// one result, the queue two and the front end one before in_ready stays low.
module wind_vane_average_classifier_unit
    import wvac_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sample_t  vane_sample,
    output logic     out_valid,
    input  logic     out_ready,
    output sample_t  mean_level,
    output code_t    heading_code,
    output used_t    samples_used,
    input  logic     cfg_wr_en,
    input  cfg_idx_t cfg_index,
    input  sample_t  cfg_wdata
);

    localparam int TW = SAMPLE_W + $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    thresh_arr_t   thresh_reg;
    logic          push_valid, push_ready;
    logic [TW-1:0] push_total;
    logic [CW-1:0] push_count;
    logic          pop_valid, pop_ready;
    logic [TW+CW-1:0] pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_wr_en)
        begin
            for (int i = 0; i < NUM_THRESH; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    thresh_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    wvac_front #(
        .DEPTH (DEPTH),
        .TW    (TW),
        .CW    (CW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .vane_sample (vane_sample),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_total  (push_total),
        .push_count  (push_count)
    );

    wvac_queue #(
        .W (TW + CW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_total, push_count}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    wvac_back #(
        .TW (TW),
        .CW (CW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .thresholds   (thresh_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_total    (pop_data[TW+CW-1:CW]),
        .pop_count    (pop_data[CW-1:0]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mean_level   (mean_level),
        .heading_code (heading_code),
        .samples_used (samples_used)
    );

endmodule

>>> src/wvac_front.sv
module wvac_front
    import wvac_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int SW    = $clog2(DEPTH),
    parameter int TW    = SAMPLE_W + $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sample_t       vane_sample,
    output logic          push_valid,
    input  logic          push_ready,
    output logic [TW-1:0] push_total,
    output logic [CW-1:0] push_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          filled_reg, filled_next;
    logic [TW-1:0] total_reg, total_next;
    sample_t       sample_reg;
    sample_t       rd_data_reg;
    sample_t       old_sample;

    sample_t ring_mem [DEPTH];

    // Slots not yet written during warm-up count as zero, so the old value is
    // taken from the memory only once the ring has wrapped.
    assign old_sample = filled_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg  <= vane_sample;
            rd_data_reg <= ring_mem[slot_reg];
        end
        if (state_reg == ST_CALC)
        begin
            ring_mem[slot_reg] <= sample_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        filled_next = filled_reg;
        total_next  = total_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                total_next = total_reg - TW'(old_sample) + TW'(sample_reg);
                if (slot_reg == SW'(DEPTH - 1))
                begin
                    slot_next   = '0;
                    filled_next = 1'b1;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            slot_reg   <= '0;
            filled_reg <= 1'b0;
            total_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            filled_reg <= filled_next;
            total_reg  <= total_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);
    assign push_total = total_reg;
    // After the update the slot pointer already equals the warm-up count.
    assign push_count = filled_reg ? CW'(DEPTH) : CW'(slot_reg);

endmodule

>>> src/wvac_queue.sv
module wvac_queue
#(
    parameter int W = 19
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] entry_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

>>> src/wvac_back.sv
module wvac_back
    import wvac_pkg::*;
#(
    parameter int TW = 15,
    parameter int CW = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  thresh_arr_t   thresholds,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  logic [TW-1:0] pop_total,
    input  logic [CW-1:0] pop_count,
    output logic          out_valid,
    input  logic          out_ready,
    output sample_t       mean_level,
    output code_t         heading_code,
    output used_t         samples_used
);

    localparam int STEP_W = $clog2(TW + 1);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_OUT  = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [TW-1:0]   quo_reg;
    logic [CW-1:0]   rem_reg;
    logic [CW-1:0]   div_reg;
    logic            out_valid_reg;
    sample_t         mean_reg;
    code_t           code_reg;
    used_t           used_reg;

    logic [CW:0]     trial;
    logic [CW:0]     diff;
    logic            q_bit;
    logic            load_out;
    sample_t         mean_val;

    // One quotient bit per cycle, restoring form.
    assign trial    = {rem_reg, quo_reg[TW-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign q_bit    = (trial >= {1'b0, div_reg});
    assign mean_val = quo_reg[SAMPLE_W-1:0];
    assign load_out = (state_reg == B_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == B_IDLE) && pop_valid)
        begin
            quo_reg  <= pop_total;
            rem_reg  <= '0;
            div_reg  <= pop_count;
            step_reg <= STEP_W'(TW);
        end
        else if (state_reg == B_DIV)
        begin
            quo_reg  <= {quo_reg[TW-2:0], q_bit};
            rem_reg  <= q_bit ? diff[CW-1:0] : trial[CW-1:0];
            step_reg <= step_reg - 1'b1;
        end
        if (load_out)
        begin
            mean_reg <= mean_val;
            code_reg <= classify(mean_val, thresholds);
            used_reg <= USED_W'(div_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign pop_ready    = (state_reg == B_IDLE);
    assign out_valid    = out_valid_reg;
    assign mean_level   = mean_reg;
    assign heading_code = code_reg;
    assign samples_used = used_reg;

endmodule

>>> src/wvac_checker.sv
module wvac_checker
    import wvac_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t mean_level,
    input code_t   heading_code,
    input used_t   samples_used
);

    // The output register is cleared asynchronously.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_code <= CODE_W))
        else $error("heading code out of range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((DEPTH >= 16) || ((samples_used != 0) && (samples_used <= DEPTH))))
        else $error("sample count out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(mean_level)
            && $stable(heading_code) && $stable(samples_used)))
        else $error("stalled result changed");

endmodule

bind wind_vane_average_classifier_unit wvac_checker #(.DEPTH(DEPTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mean_level   (mean_level),
    .heading_code (heading_code),
    .samples_used (samples_used)
);
